### hdl/box_blur_line_pass_top_assert.svh
`ifndef BOX_BLUR_LINE_PASS_TOP_ASSERT_SVH
`define BOX_BLUR_LINE_PASS_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BBLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("box blur line pass: port check failed");

// Next-cycle implication, checked outside reset.
`define BBLP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("box blur line pass: port check failed");

`endif

### hdl/bblp_pkg.sv
package bblp_pkg;

  localparam int MAX_RADIUS     = 15;
  localparam int MAX_LINE_WIDTH = 512;

  localparam int HIST_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);

  localparam int CH_W   = 8;
  localparam int NUM_CH = 4;
  localparam int PIX_W  = CH_W * NUM_CH;

  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int LEN_W = $clog2(HIST_DEPTH + 1);
  localparam int SUM_W = $clog2(HIST_DEPTH * 255 + 1);
  localparam int POS_W = $clog2(MAX_LINE_WIDTH);
  localparam int WID_W = $clog2(MAX_LINE_WIDTH + 1);

  // Reciprocal scaling for the exact truncating divide by the window length.
  localparam int REC_K  = SUM_W + LEN_W;
  localparam int REC_W  = REC_K + 1;
  localparam int PROD_W = SUM_W + REC_W;

  localparam int CFG_RADIUS_W = 4;
  localparam int CFG_WIDTH_W  = 10;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd1;

  localparam logic [CFG_RADIUS_W-1:0] RADIUS_RESET = 4'd1;
  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 10'd480;

  typedef struct packed {
    logic             restart;
    logic             px_load;
    logic             rd_en;
    logic             rd_flush;
    logic             upd_en;
    logic             upd_init;
    logic             upd_first;
    logic             upd_write;
    logic             mul_en;
    logic             out_load;
    logic             out_last;
    logic [RAD_W-1:0] radius;
    logic [LEN_W-1:0] len;
  } bblp_cmd_t;

  typedef struct packed {
    logic out_free;
  } bblp_sts_t;

endpackage

### hdl/box_blur_line_pass_top.sv
// Horizontal (or vertical) box blur over one line of ARGB8888 pixels.
// Input beats on in_* carry one pixel each; output beats on out_* carry the
// average of the 2r+1 pixels centered on one position, with the line ends
// clamped so the first and last pixels repeat. out_tlast marks the last
// output pixel of a line. Output j is produced after input pixel j+r; the
// last pixel of a line also produces the remaining r outputs.
// Sequence: accepting a pixel also issues its history read, and a
// running-sum update follows. A pixel that yields an output then goes
// through the reciprocal multiply and the output register load; each
// further end-of-line output repeats read, update, multiply and load.
// The output register holds a result while the receiver stalls; the block
// then waits in its output step with in_tready low until the beat is taken.
// Reset (synchronous, active low) sets radius 1, line width 480 and starts a
// new line. Any cfg write also abandons the line in progress.
// The history memory is never cleared; only slots already written in the
// current line are used.
module box_blur_line_pass_top (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata fields from bit 0: in_alpha, in_red, in_green, in_blue (8 bits each)
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bblp_pkg::PIX_W-1:0]         in_tdata,
  // out_tdata fields from bit 0: out_alpha, out_red, out_green, out_blue
  // (8 bits each); out_tlast carries line_end
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bblp_pkg::PIX_W-1:0]         out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_we,
  input  logic [bblp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [bblp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import bblp_pkg::*;

  logic [CFG_RADIUS_W-1:0] radius_r;
  logic [CFG_WIDTH_W-1:0]  line_width_r;
  bblp_cmd_t               cmd;
  bblp_sts_t               sts;

  // Configuration registers. The controller derives the effective radius
  // and width from them, so they are stored exactly as written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RADIUS_RESET;
      line_width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RADIUS: begin
          radius_r <= cfg_wdata[CFG_RADIUS_W-1:0];
        end
        REG_LINE_WIDTH: begin
          line_width_r <= cfg_wdata[CFG_WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The controller sequences each pixel and the end-of-line flush.
  bblp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .cfg_we     (cfg_we),
    .radius_cfg (radius_r),
    .width_cfg  (line_width_r),
    .sts        (sts),
    .cmd        (cmd)
  );

  // The datapath holds the pixel history, running sums, divider and
  // output register.
  bblp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### hdl/bblp_ram.sv
module bblp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 31
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/bblp_ctrl.sv
module bblp_ctrl (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic                                cfg_we,
  input  logic [bblp_pkg::CFG_RADIUS_W-1:0]   radius_cfg,
  input  logic [bblp_pkg::CFG_WIDTH_W-1:0]    width_cfg,
  input  bblp_pkg::bblp_sts_t                 sts,
  output bblp_pkg::bblp_cmd_t                 cmd
);

  import bblp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             main_r, main_nxt;
  logic [RAD_W-1:0] flush_left_r, flush_left_nxt;
  logic             flush_first_r, flush_first_nxt;

  logic [WID_W-1:0] w_eff;
  logic [WID_W-1:0] r_lim;
  logic [RAD_W-1:0] r_sat;
  logic [RAD_W-1:0] r_eff;
  logic [LEN_W-1:0] len;
  logic             p_last;
  logic             p_zero;
  logic             p_in_first;
  logic             p_emit;
  logic             p_mirror;

  // Effective line width and radius; the radius shrinks so the window fits the line.
  always_comb begin
    if (32'(width_cfg) > 32'(MAX_LINE_WIDTH)) begin
      w_eff = WID_W'(MAX_LINE_WIDTH);
    end else if (width_cfg == '0) begin
      w_eff = WID_W'(1);
    end else begin
      w_eff = WID_W'(width_cfg);
    end
    if (32'(radius_cfg) > 32'(MAX_RADIUS)) begin
      r_sat = RAD_W'(MAX_RADIUS);
    end else begin
      r_sat = RAD_W'(radius_cfg);
    end
    r_lim = (w_eff - WID_W'(1)) >> 1;
    if (32'(r_sat) > 32'(r_lim)) begin
      r_eff = RAD_W'(r_lim);
    end else begin
      r_eff = r_sat;
    end
    len = LEN_W'({r_eff, 1'b1});
  end

  assign p_last     = (pos_r == POS_W'(w_eff - WID_W'(1)));
  assign p_zero     = (pos_r == '0);
  assign p_in_first = (32'(pos_r) <= 32'(len));
  assign p_emit     = (32'(pos_r) >= 32'(r_eff));
  assign p_mirror   = (32'(pos_r) == 32'(len) - 32'd1);

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    main_nxt        = main_r;
    flush_left_nxt  = flush_left_r;
    flush_first_nxt = flush_first_r;
    cmd             = '0;
    cmd.radius      = r_eff;
    cmd.len         = len;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.px_load = 1'b1;
          cmd.rd_en   = 1'b1;
          main_nxt    = 1'b1;
          state_nxt   = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.upd_en = 1'b1;
        if (main_r) begin
          cmd.upd_init  = p_zero;
          cmd.upd_first = p_in_first;
          cmd.upd_write = 1'b1;
          if (p_emit) begin
            state_nxt = ST_MUL;
          end else begin
            // A pixel before the first full window never ends the line.
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          cmd.upd_first = flush_first_r;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (main_r) begin
            cmd.out_last = p_last && (r_eff == '0);
            if (p_last && (r_eff == '0)) begin
              cmd.restart = 1'b1;
              pos_nxt     = '0;
              state_nxt   = ST_IDLE;
            end else if (p_last) begin
              cmd.rd_en       = 1'b1;
              cmd.rd_flush    = 1'b1;
              main_nxt        = 1'b0;
              flush_left_nxt  = r_eff - 1'b1;
              flush_first_nxt = p_mirror;
              state_nxt       = ST_UPD;
            end else begin
              pos_nxt   = pos_r + 1'b1;
              state_nxt = ST_IDLE;
            end
          end else begin
            cmd.out_last = (flush_left_r == '0);
            if (flush_left_r == '0) begin
              cmd.restart = 1'b1;
              pos_nxt     = '0;
              state_nxt   = ST_IDLE;
            end else begin
              cmd.rd_en       = 1'b1;
              cmd.rd_flush    = 1'b1;
              flush_left_nxt  = flush_left_r - 1'b1;
              flush_first_nxt = 1'b0;
              state_nxt       = ST_UPD;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      cmd.restart = 1'b1;
      pos_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      pos_r         <= '0;
      main_r        <= 1'b0;
      flush_left_r  <= '0;
      flush_first_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      main_r        <= main_nxt;
      flush_left_r  <= flush_left_nxt;
      flush_first_r <= flush_first_nxt;
    end
  end

endmodule

### hdl/bblp_dp.sv
module bblp_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bblp_pkg::PIX_W-1:0]   in_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bblp_pkg::PIX_W-1:0]   out_tdata,
  output logic                         out_tlast,
  input  bblp_pkg::bblp_cmd_t          cmd,
  output bblp_pkg::bblp_sts_t          sts
);

  import bblp_pkg::*;

  logic [PIX_W-1:0]   px_r;
  logic [PIX_W-1:0]   first_r;
  logic [SUM_W-1:0]   sums_r [NUM_CH];
  logic [PROD_W-1:0]  prod_r [NUM_CH];
  logic [HIST_AW-1:0] wp_r, wp_nxt;
  logic [HIST_AW-1:0] fp_r, fp_nxt;
  logic               out_valid_r;
  logic [PIX_W-1:0]   out_data_r;
  logic               out_last_r;

  logic [HIST_AW:0]   addr_sum;
  logic [HIST_AW-1:0] addr_main;
  logic [HIST_AW-1:0] raddr;
  logic [PIX_W-1:0]   rdata;
  logic [PIX_W-1:0]   old_px;
  logic [REC_W-1:0]   recip_tab [MAX_RADIUS+1];
  logic [REC_W-1:0]   recip;

  function automatic logic [HIST_AW-1:0] ptr_inc(input logic [HIST_AW-1:0] p);
    logic [HIST_AW-1:0] q;
    if (p == HIST_AW'(HIST_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  // Reciprocal of each window length 2r+1, rounded up: exact for every sum.
  for (genvar g = 0; g <= MAX_RADIUS; g++) begin : g_rec
    localparam longint unsigned Dv = 2 * g + 1;
    localparam logic [REC_W-1:0] RecV = REC_W'(((64'd1 << REC_K) + Dv - 1) / Dv);
    assign recip_tab[g] = RecV;
  end

  assign recip = recip_tab[cmd.radius];

  // Ring slot of the pixel leaving the window: (wp - len) mod depth.
  always_comb begin
    addr_sum = {1'b0, wp_r} + (HIST_AW+1)'(HIST_DEPTH) - (HIST_AW+1)'(cmd.len);
    if (addr_sum >= (HIST_AW+1)'(HIST_DEPTH)) begin
      addr_sum = addr_sum - (HIST_AW+1)'(HIST_DEPTH);
    end
    addr_main = addr_sum[HIST_AW-1:0];
  end

  assign raddr = cmd.rd_flush ? fp_r : addr_main;

  bblp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.upd_en && cmd.upd_write),
    .waddr (wp_r),
    .wdata (px_r),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign old_px = cmd.upd_first ? first_r : rdata;

  always_comb begin
    wp_nxt = wp_r;
    fp_nxt = fp_r;
    if (cmd.rd_en) begin
      fp_nxt = cmd.rd_flush ? ptr_inc(fp_r) : ptr_inc(addr_main);
    end
    if (cmd.upd_en && cmd.upd_write) begin
      wp_nxt = ptr_inc(wp_r);
    end
    if (cmd.restart) begin
      wp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      fp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r <= wp_nxt;
      fp_r <= fp_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.px_load) begin
      px_r <= in_tdata;
    end
    if (cmd.upd_en && cmd.upd_init) begin
      first_r <= px_r;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.upd_en) begin
        if (cmd.upd_init) begin
          sums_r[c] <= SUM_W'(cmd.len) * SUM_W'(px_r[c*CH_W +: CH_W]);
        end else begin
          sums_r[c] <= sums_r[c] + SUM_W'(px_r[c*CH_W +: CH_W])
                       - SUM_W'(old_px[c*CH_W +: CH_W]);
        end
      end
      if (cmd.mul_en) begin
        prod_r[c] <= PROD_W'(sums_r[c]) * PROD_W'(recip);
      end
      if (cmd.out_load) begin
        out_data_r[c*CH_W +: CH_W] <= prod_r[c][REC_K +: CH_W];
      end
    end
    if (cmd.out_load) begin
      out_last_r <= cmd.out_last;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;

endmodule

### hdl/bblp_checker.sv
`include "box_blur_line_pass_top_assert.svh"

module bblp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [bblp_pkg::PIX_W-1:0]         out_tdata,
  input logic                               out_tlast
);

  import bblp_pkg::*;

  // A stalled result keeps its data.
  `BBLP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast))

  // Only one pixel is in work at a time.
  `BBLP_ASSERT_NXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

  // A result needs the update and multiply steps after its pixel.
  `BBLP_ASSERT_IMP(a_no_early_result, $rose(out_tvalid), !$past(in_tvalid && in_tready))

  // The output register is never loaded while input is being taken.
  `BBLP_ASSERT_NXT(a_quiet_while_ready, in_tready && !out_tvalid, !out_tvalid)

endmodule

bind box_blur_line_pass_top bblp_checker u_bblp_checker (.*);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import bblp_pkg::*;

  // One pixel as it travels on in_tdata and out_tdata: alpha sits in the
  // lowest byte, so it is the last member of the packed struct.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
  } argb_t;

  // One expected output beat: the averaged pixel and the line end flag.
  typedef struct {
    argb_t px;
    logic  line_end;
  } blur_beat_t;

  localparam int RANDOM_ITEMS = 320;
  // Long output stall used to fill the block and back-pressure its input.
  localparam int HOLD_CYCLES  = 300;
  // Settle time after the last expected beat. A pixel that makes no output
  // can still be in flight.
  localparam int DRAIN_CYCLES = 16;
  // About ten times the slowest plausible run.
  localparam int TIMEOUT_NS   = 2_000_000;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  box_blur_line_pass_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off here if the block hangs or loses beats.
  initial begin
    #(TIMEOUT_NS);
    $display("tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Blur predictor. It mirrors the block's register settings, its four
  // running channel sums, the ring of recent pixels and the line position.
  // Reset values match the block: radius 1, width 480, empty line.
  // ---------------------------------------------------------------------
  logic [3:0]  blur_radius = 4'd1;
  logic [9:0]  blur_width  = 10'd480;
  int unsigned ch_sum [4]  = '{default: 0};
  argb_t       line_hist [HIST_DEPTH];
  argb_t       line_first  = '0;
  int unsigned line_pos    = 0;

  blur_beat_t  pending_avgs [$];   // averages still owed by the block
  argb_t       pixels_to_send [$]; // pixels waiting for the sender

  int unsigned errors      = 0;
  int unsigned n_pixels    = 0;
  int unsigned n_avgs      = 0;
  int unsigned n_line_ends = 0;
  int unsigned n_cfg       = 0;

  function automatic void clear_line();
    line_pos = 0;
    for (int c = 0; c < 4; c++) ch_sum[c] = 0;
  endfunction

  // Move the window one step: the newest pixel enters, the oldest leaves.
  function automatic void slide_sums(argb_t add_px, argb_t drop_px);
    for (int c = 0; c < 4; c++)
      ch_sum[c] = ch_sum[c] + add_px[8*c +: 8] - drop_px[8*c +: 8];
  endfunction

  // The block divides with truncation, so plain integer division matches.
  function automatic void push_average(int unsigned len, logic last);
    blur_beat_t b;
    for (int c = 0; c < 4; c++) b.px[8*c +: 8] = 8'(ch_sum[c] / len);
    b.line_end = last;
    pending_avgs.push_back(b);
  endfunction

  // Work out every average that one accepted pixel releases.
  function automatic void predict_blur(argb_t px);
    int unsigned w, r, len, j, idx;
    argb_t       drop;
    // Width 0 behaves as 1 and widths past the maximum saturate. The radius
    // shrinks so that the window never exceeds the line.
    w = blur_width;
    if (w == 0) w = 1;
    if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
    r = blur_radius;
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (2 * r + 1 > w) r = (w - 1) / 2;
    len = 2 * r + 1;

    if (line_pos == 0) begin
      // The left edge is clamped: the first pixel fills the whole window.
      line_first = px;
      for (int c = 0; c < 4; c++) ch_sum[c] = len * px[8*c +: 8];
    end else begin
      drop = (line_pos <= len) ? line_first : line_hist[(line_pos - len) % HIST_DEPTH];
      slide_sums(px, drop);
    end
    line_hist[line_pos % HIST_DEPTH] = px;

    // Output j appears once pixel j+r is in. With radius 0 that is the pixel
    // itself, so the last one of the line also marks the line end.
    if (line_pos >= r) push_average(len, (line_pos + 1 >= w) && (r == 0));

    if (line_pos + 1 >= w) begin
      // Right edge: the last pixel repeats and flushes the remaining r outputs.
      for (j = w - r; j < w; j++) begin
        idx  = j - r - 1;
        drop = (idx == 0) ? line_first : line_hist[idx % HIST_DEPTH];
        slide_sums(px, drop);
        push_average(len, j == w - 1);
      end
      clear_line();
    end else begin
      line_pos++;
    end
  endfunction

  // ---------------------------------------------------------------------
  // Sender. It takes pixels from pixels_to_send and offers them on in_*.
  // After each pixel it idles for a random number of cycles when idling is
  // enabled for the current phase. The predictor runs on every accepted beat.
  // ---------------------------------------------------------------------
  bit    tx_idle_on = 1'b1;
  int    tx_gap     = 0;
  argb_t tx_px      = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_blur(tx_px);
        n_pixels++;
      end
      // A new beat may be offered only once the current one has gone.
      if (!in_tvalid || in_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (pixels_to_send.size() != 0) begin
          tx_px = pixels_to_send.pop_front();
          in_tdata  <= tx_px;
          in_tvalid <= 1'b1;
          tx_gap = tx_idle_on ? $urandom_range(0, 11) : 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Receiver. Every output beat is compared with the oldest expected
  // average. Between beats the receiver stalls for a random number of
  // cycles. On request it also holds off for a long stretch, so the block's
  // output register stays full and in_tready has to drop.
  // ---------------------------------------------------------------------
  bit    rx_idle_on    = 1'b1;
  int    rx_stall      = 0;
  int    rx_hold       = 0;
  int    hold_requests = 0;
  int    hold_served   = 0;
  argb_t rx_px;

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t tb: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        rx_px = out_tdata;
        n_avgs++;
        if (out_tlast) n_line_ends++;
        if (pending_avgs.size() == 0) begin
          $display("%0t tb: unexpected beat, expected none, actual %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          blur_beat_t want;
          want = pending_avgs.pop_front();
          check_field("alpha", want.px.alpha, rx_px.alpha);
          check_field("red", want.px.red, rx_px.red);
          check_field("green", want.px.green, rx_px.green);
          check_field("blue", want.px.blue, rx_px.blue);
          check_field("line_end", 8'(want.line_end), 8'(out_tlast));
        end
        rx_stall = rx_idle_on ? $urandom_range(0, 11) : 0;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        rx_hold = HOLD_CYCLES;
      end
      if (rx_hold != 0) begin
        rx_hold--;
        out_tready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Random pixel; about one channel in six is forced to all zeros or all ones
  // so that the sums also hit their extremes.
  function automatic argb_t rand_pixel();
    logic [31:0] v;
    v = $urandom;
    for (int c = 0; c < 4; c++)
      if ($urandom_range(0, 5) == 0) v[8*c +: 8] = {8{v[8*c]}};
    return argb_t'(v);
  endfunction

  // Wait until the sender is empty and every expected beat has been seen,
  // then let the last pixels that make no output finish inside the block.
  task automatic wait_idle();
    @(negedge clk);
    while (pixels_to_send.size() != 0 || in_tvalid || pending_avgs.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes on back-to-back edges. Any write drops the line in
  // progress, so the predictor starts a new line as well.
  task automatic write_regs(bit set_r, logic [3:0] r, bit set_w, logic [9:0] w);
    if (set_r) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_RADIUS;
      cfg_wdata <= CFG_DATA_W'(r);
      blur_radius = r;
      n_cfg++;
    end
    if (set_w) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= REG_LINE_WIDTH;
      cfg_wdata <= CFG_DATA_W'(w);
      blur_width = w;
      n_cfg++;
    end
    clear_line();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Close the previous phase, write new settings and pick the idling mode.
  // Returns on a falling edge, where the pixel queue may be filled.
  task automatic start_phase(bit set_r, logic [3:0] r, bit set_w, logic [9:0] w,
                             bit tx_idle, bit rx_idle);
    wait_idle();
    write_regs(set_r, r, set_w, w);
    @(negedge clk);
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned rand_items;
    int unsigned n;
    int unsigned eff;
    int          pick;
    logic [3:0]  r;
    logic [9:0]  w;
    bit          set_r;
    bit          set_w;

    rand_items = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings (radius 1, width 480): a few pixels of a line that a
    // register write later abandons. The values cover both channel extremes.
    @(negedge clk);
    pixels_to_send.push_back(argb_t'(32'h0000_0000));
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));
    pixels_to_send.push_back(argb_t'(32'hAA55_55AA));

    // Radius 0 on one-pixel lines: plain pass-through, every beat a line end.
    start_phase(1'b1, 4'd0, 1'b1, 10'd1, 1'b1, 1'b1);
    pixels_to_send.push_back(argb_t'(32'h1234_5678));
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));

    // Radius 2 on a five-pixel line: both edges clamp into the window.
    start_phase(1'b1, 4'd2, 1'b1, 10'd5, 1'b0, 1'b1);
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));
    pixels_to_send.push_back(argb_t'(32'h0000_0000));
    pixels_to_send.push_back(argb_t'(32'h0F0F_F0F0));
    pixels_to_send.push_back(rand_pixel());
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));

    // The largest radius on a two-pixel line shrinks to 0.
    start_phase(1'b1, 4'd15, 1'b1, 10'd2, 1'b1, 1'b0);
    pixels_to_send.push_back(argb_t'(32'h00FF_00FF));
    pixels_to_send.push_back(argb_t'(32'hFF00_FF00));

    // On a three-pixel line it shrinks to 1.
    start_phase(1'b0, 4'd0, 1'b1, 10'd3, 1'b1, 1'b1);
    pixels_to_send.push_back(rand_pixel());
    pixels_to_send.push_back(argb_t'(32'hFFFF_FFFF));
    pixels_to_send.push_back(argb_t'(32'h0000_0000));

    // Width 0 is treated as a one-pixel line.
    start_phase(1'b0, 4'd0, 1'b1, 10'd0, 1'b1, 1'b1);
    pixels_to_send.push_back(rand_pixel());

    // Width 1023 saturates to the maximum. With radius 15 these pixels make
    // no output, and the next register write throws the line away.
    start_phase(1'b0, 4'd0, 1'b1, 10'd1023, 1'b1, 1'b1);
    repeat (9) pixels_to_send.push_back(rand_pixel());

    // Full 31-pixel window on a 40-pixel line. The sender runs without gaps
    // while the receiver holds off for a long time, so the block fills up
    // and has to stall its input.
    start_phase(1'b1, 4'd15, 1'b1, 10'd40, 1'b0, 1'b1);
    hold_requests++;
    repeat (40) pixels_to_send.push_back(rand_pixel());
    rand_items += 40;

    // Random phases. Most of them are whole lines, sometimes followed by a
    // partial line that the next write discards. A few use widths of 0 or
    // beyond the maximum, and long widths only get partial lines.
    while (rand_items < RANDOM_ITEMS) begin
      pick  = $urandom_range(0, 19);
      r     = 4'($urandom_range(0, 15));
      set_r = $urandom_range(0, 3) != 0;
      set_w = !set_r || ($urandom_range(0, 1) != 0);
      if (pick < 13)       w = 10'($urandom_range(1, 24));
      else if (pick < 16)  w = 10'($urandom_range(25, 64));
      else if (pick == 16) w = 10'd0;
      else if (pick == 17) w = 10'($urandom_range(513, 1023));
      else                 w = 10'($urandom_range(480, 512));
      if (!set_w) w = blur_width;
      eff = (w == 0) ? 1 : ((w > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : w);
      if (eff <= 64) begin
        n = eff * $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0) n += $urandom_range(0, eff - 1);
      end else begin
        n = $urandom_range(10, 40);
      end
      // The last phase is cut short so the total stays near the target.
      if (n > RANDOM_ITEMS - rand_items) n = RANDOM_ITEMS - rand_items;
      start_phase(set_r, r, set_w, w, $urandom_range(0, 3) != 0,
                  $urandom_range(0, 3) != 0);
      repeat (n) pixels_to_send.push_back(rand_pixel());
      rand_items += n;
    end

    wait_idle();
    $display("tb: %0d pixels sent, %0d averages checked, %0d line ends, %0d register writes",
             n_pixels, n_avgs, n_line_ends, n_cfg);
    $display("tb: radius 0 to 15, widths 0 to 1023, abandoned lines and a %0d-cycle stall",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
